FILE: rtl/core/lrut_pkg.sv
// ----------------------------------------------------------------------------
// LRU tracker package
// Sizes, operation and status codes, and the broadcast buses of the cell row.
// ----------------------------------------------------------------------------
package lrut_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 8;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_TOUCH = 2'd0,
    OP_EVICT = 2'd1,
    OP_ERASE = 2'd2,
    OP_NONE  = 2'd3
  } lrut_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } lrut_status_t;

  // Search bus: every cell compares its key against this one.
  typedef struct packed {
    logic                search_en;
    logic [KEY_BITS-1:0] key;
  } lrut_srch_t;

  // Update bus: shift enable and the key written into the selected cell.
  typedef struct packed {
    logic                shift_en;
    logic [KEY_BITS-1:0] key;
  } lrut_upd_t;

endpackage

FILE: rtl/core/lru_replacement_tracker.sv
// ----------------------------------------------------------------------------
// LRU replacement tracker
// Keeps up to ENTRIES distinct keys in recency order in a row of cells.
// ----------------------------------------------------------------------------
// Usage: a command word is taken at every clock edge where start is high;
// busy stays low, so a new command may follow in every cycle. The command is
// registered, executed against the cell row in the next cycle, and its result
// word is driven on the out_ ports with out_strobe from the next edge on, for
// one cycle only. The receiver cannot stall and must take each result word as
// it comes. Slot 0 of the row holds the least recent key; all cells compare
// against the key in parallel and the row shifts down by one behind the
// removed key in the same cycle, which is what sets the rate of one command
// per cycle. No clearing pass is needed after reset.
module lru_replacement_tracker
  import lrut_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_op,
  input  logic [KEY_BITS-1:0] in_key,
  output logic                out_strobe,
  output logic [ST_W-1:0]     out_status,
  output logic [KEY_BITS-1:0] out_victim_key,
  output logic [OCC_W-1:0]    out_occupancy
);

  logic                cmd_vld_r;
  lrut_op_t            op_r;
  logic [KEY_BITS-1:0] key_r;

  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic [CNT_W-1:0]    wr_idx;

  logic                strobe_r;
  lrut_status_t        status_r;
  lrut_status_t        status_nxt;
  logic [KEY_BITS-1:0] victim_r;
  logic [KEY_BITS-1:0] victim_nxt;

  lrut_srch_t          srch;
  lrut_upd_t           upd;
  logic [ENTRIES:0]    chain;
  logic [ENTRIES-1:0]  cell_valid;
  logic [KEY_BITS-1:0] cell_key [ENTRIES];
  logic [ENTRIES-1:0]  wr_sel;
  logic                hit;
  logic                full;
  logic                empty;
  logic                do_write;

  // Busy is tied low, so the block never holds off start.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= lrut_op_t'(in_op);
    key_r <= in_key;
  end

  assign full  = (cnt_r >= CNT_W'(ENTRIES));
  assign empty = (cnt_r == '0);

  assign srch.search_en = cmd_vld_r && ((op_r == OP_TOUCH) || (op_r == OP_ERASE));
  assign srch.key       = key_r;

  // An evict removes slot 0, so the shift chain starts already set.
  assign chain[0] = cmd_vld_r && (op_r == OP_EVICT);
  assign hit      = srch.search_en && chain[ENTRIES];

  assign do_write     = cmd_vld_r && (op_r == OP_TOUCH) && (hit || !full);
  assign upd.shift_en = hit || (chain[0] && !empty);
  assign upd.key      = key_r;

  // A hit frees one slot below the top, so the touched key lands one lower.
  assign wr_idx = hit ? (cnt_r - CNT_W'(1)) : cnt_r;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                up_v;
    logic [KEY_BITS-1:0] up_k;

    assign wr_sel[i] = do_write && (wr_idx == CNT_W'(i));

    if (i == ENTRIES - 1) begin : g_top
      assign up_v = 1'b0;
      assign up_k = '0;
    end else begin : g_mid
      assign up_v = cell_valid[i+1];
      assign up_k = cell_key[i+1];
    end

    lrut_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .srch      (srch),
      .upd       (upd),
      .wr_sel    (wr_sel[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .up_valid  (up_v),
      .up_key    (up_k),
      .valid     (cell_valid[i]),
      .key       (cell_key[i])
    );
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    victim_nxt = '0;
    case (op_r)
      OP_TOUCH: begin
        if (!hit && full) begin
          status_nxt = ST_FULL;
        end else if (!hit) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      OP_EVICT: begin
        if (empty) begin
          status_nxt = ST_MISS;
        end else begin
          victim_nxt = cell_key[0];
          cnt_nxt    = cnt_r - CNT_W'(1);
        end
      end
      OP_ERASE: begin
        if (hit) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          status_nxt = ST_MISS;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd_vld_r;
      if (cmd_vld_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    victim_r <= victim_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_victim_key = victim_r;
  assign out_occupancy  = OCC_W'(cnt_r);

  // Valid slots stay packed at the low end and match the count.
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid == ENTRIES'(((ENTRIES+1)'(1) << cnt_r) - (ENTRIES+1)'(1)))
    else $error("valid cells not packed to occupancy");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##2 out_strobe)
    else $error("result word missing two cycles after command");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_FULL)) |-> (cnt_r == CNT_W'(ENTRIES)))
    else $error("full status with free slots");

  a_evict_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_vld_r && (op_r == OP_EVICT) && !empty) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("evict did not lower occupancy");

endmodule

FILE: rtl/core/lrut_cell.sv
// ----------------------------------------------------------------------------
// LRU tracker cell
// One recency slot: holds a key and its valid bit, compares against the search
// key and takes its upper neighbor's contents when the row shifts down.
// ----------------------------------------------------------------------------
module lrut_cell
  import lrut_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  lrut_srch_t          srch,
  input  lrut_upd_t           upd,
  input  logic                wr_sel,
  input  logic                chain_in,
  output logic                chain_out,
  input  logic                up_valid,
  input  logic [KEY_BITS-1:0] up_key,
  output logic                valid,
  output logic [KEY_BITS-1:0] key
);

  logic                valid_r;
  logic                valid_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] key_nxt;
  logic                match;
  logic                shift;

  assign match     = srch.search_en && valid_r && (key_r == srch.key);
  // The chain marks every slot at or above the one that leaves the order.
  assign chain_out = chain_in || match;
  assign shift     = upd.shift_en && chain_out;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (wr_sel) begin
      valid_nxt = 1'b1;
      key_nxt   = upd.key;
    end else if (shift) begin
      valid_nxt = up_valid;
      key_nxt   = up_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign valid = valid_r;
  assign key   = key_r;

endmodule

FILE: tb/lru_replacement_tracker_test.sv
// ----------------------------------------------------------------------------
// LRU replacement tracker testbench
// Drives touch, evict, erase and unused command words into the tracker with
// random gaps. Every accepted word is run through a behavioral recency list
// kept here, and each result word is compared field by field with the oldest
// expected one. A short directed table covers the corner cases first.
// ----------------------------------------------------------------------------
module lru_replacement_tracker_test;
  import lrut_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 650;
  localparam int BLOCK_WORDS  = 50;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    lrut_status_t        status;
    logic [KEY_BITS-1:0] victim;
    logic [OCC_W-1:0]    occupancy;
  } tracker_word_t;

  typedef struct packed {
    lrut_op_t            op;
    logic [KEY_BITS-1:0] key;
    logic                typed;
    lrut_status_t        status;
    logic [KEY_BITS-1:0] victim;
    logic [OCC_W-1:0]    occupancy;
  } command_row_t;

  logic                clk;
  logic                rst_n  = 1'b0;
  logic                start  = 1'b0;
  logic [OP_W-1:0]     in_op  = OP_TOUCH;
  logic [KEY_BITS-1:0] in_key = '0;
  logic                busy;
  logic                out_strobe;
  logic [ST_W-1:0]     out_status;
  logic [KEY_BITS-1:0] out_victim_key;
  logic [OCC_W-1:0]    out_occupancy;

  // Recency list: slot 0 is the least recent key.
  logic [KEY_BITS-1:0] recency_row [ENTRIES];
  int                  tracked_keys = 0;
  tracker_word_t       expected_words [$];
  int                  mismatches = 0;
  command_row_t        corner_rows [DIRECTED_ROWS];

  lru_replacement_tracker u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_key         (in_key),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_victim_key (out_victim_key),
    .out_occupancy  (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_key(logic [KEY_BITS-1:0] key);
    for (int i = 0; i < tracked_keys; i++) begin
      if (recency_row[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < tracked_keys; i++) begin
      recency_row[i] = recency_row[i + 1];
    end
    tracked_keys--;
  endfunction

  function automatic tracker_word_t apply_command(lrut_op_t op, logic [KEY_BITS-1:0] key);
    tracker_word_t res;
    int            pos;
    res.status = ST_OK;
    res.victim = '0;
    case (op)
      OP_TOUCH: begin
        pos = find_key(key);
        if (pos >= 0) begin
          drop_slot(pos);
          recency_row[tracked_keys] = key;
          tracked_keys++;
        end else if (tracked_keys >= ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          recency_row[tracked_keys] = key;
          tracked_keys++;
        end
      end
      OP_EVICT: begin
        if (tracked_keys == 0) begin
          res.status = ST_MISS;
        end else begin
          res.victim = recency_row[0];
          drop_slot(0);
        end
      end
      OP_ERASE: begin
        pos = find_key(key);
        if (pos >= 0) drop_slot(pos);
        else res.status = ST_MISS;
      end
      default: begin
      end
    endcase
    res.occupancy = OCC_W'(tracked_keys);
    return res;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Holds the word on the ports until the edge that takes it, then records
  // the expected result. A typed row overrides the computed result.
  task automatic issue(lrut_op_t op, logic [KEY_BITS-1:0] key, int gap,
                       logic typed, tracker_word_t want);
    tracker_word_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_op  <= op;
    in_key <= key;
    do @(posedge clk); while (busy);
    predicted = apply_command(op, key);
    expected_words.insert(expected_words.size(), typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    tracker_word_t want;
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        note_mismatch($sformatf("result word st=%0d vic=%02h occ=%0d with nothing pending",
                                out_status, out_victim_key, out_occupancy));
      end else begin
        want = expected_words.pop_front();
        if (out_status !== want.status || out_victim_key !== want.victim ||
            out_occupancy !== want.occupancy) begin
          note_mismatch($sformatf("expected st=%0d vic=%02h occ=%0d, got st=%0d vic=%02h occ=%0d",
                                  want.status, want.victim, want.occupancy,
                                  out_status, out_victim_key, out_occupancy));
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tracker_word_t want;
    lrut_op_t      op;
    logic [KEY_BITS-1:0] key;
    int            sent;
    int            pick;
    int            touch_pct;
    int            evict_pct;
    logic          calm;

    // The fill rows bring the row to exactly ENTRIES keys before the full cases.
    corner_rows = '{
      '{OP_EVICT, 8'h00, 1'b1, ST_MISS, 8'h00, 5'd0},
      '{OP_ERASE, 8'h5A, 1'b1, ST_MISS, 8'h00, 5'd0},
      '{OP_TOUCH, 8'h00, 1'b1, ST_OK,   8'h00, 5'd1},
      '{OP_TOUCH, 8'hFF, 1'b1, ST_OK,   8'h00, 5'd2},
      '{OP_EVICT, 8'h00, 1'b1, ST_OK,   8'h00, 5'd1},
      '{OP_TOUCH, 8'h01, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'h02, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'h04, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'h08, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'h10, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'h20, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'h40, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'h80, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'hFE, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'hFD, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'hFB, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'hF7, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'hEF, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'hDF, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'hBF, 1'b0, ST_OK,   8'h00, 5'd0},
      '{OP_TOUCH, 8'h7F, 1'b1, ST_FULL, 8'h00, 5'd16},
      '{OP_TOUCH, 8'hFF, 1'b1, ST_OK,   8'h00, 5'd16},
      '{OP_NONE,  8'h33, 1'b1, ST_OK,   8'h00, 5'd16},
      '{OP_ERASE, 8'hFF, 1'b1, ST_OK,   8'h00, 5'd15},
      '{OP_EVICT, 8'h00, 1'b0, ST_OK,   8'h00, 5'd0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_rows[i]) begin
      want = '{corner_rows[i].status, corner_rows[i].victim, corner_rows[i].occupancy};
      issue(corner_rows[i].op, corner_rows[i].key, $urandom_range(10),
            corner_rows[i].typed, want);
    end

    // Random blocks alternate between filling, draining and mixed traffic so
    // that both the full and the empty corners are hit repeatedly.
    sent = 0;
    want = '0;
    while (sent < RANDOM_WORDS) begin
      if (sent % BLOCK_WORDS == 0) begin
        case ((sent / BLOCK_WORDS) % 3)
          0: begin touch_pct = 70; evict_pct = 10; end
          1: begin touch_pct = 25; evict_pct = 35; end
          default: begin touch_pct = 45; evict_pct = 25; end
        endcase
        calm = ($urandom_range(3) == 0);
        if (sent / BLOCK_WORDS == (RANDOM_WORDS / BLOCK_WORDS) / 2) begin
          start <= 1'b0;
          @(posedge clk);
          while (expected_words.size() != 0) @(posedge clk);
        end
      end
      pick = $urandom_range(99);
      if (pick < 3) op = OP_NONE;
      else if (pick < 3 + touch_pct) op = OP_TOUCH;
      else if (pick < 3 + touch_pct + evict_pct) op = OP_EVICT;
      else op = OP_ERASE;
      case ($urandom_range(3))
        0: key = KEY_BITS'($urandom_range(255));
        1: key = KEY_BITS'($urandom_range(23));
        2: key = KEY_BITS'(8'hE8 + $urandom_range(23));
        default: key = (tracked_keys > 0) ? recency_row[$urandom_range(tracked_keys - 1)]
                                          : KEY_BITS'($urandom_range(255));
      endcase
      issue(op, key, calm ? 0 : $urandom_range(10), 1'b0, want);
      if (op != OP_NONE) sent++;
    end

    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/lrut_pkg.sv
rtl/core/lrut_cell.sv
rtl/core/lru_replacement_tracker.sv
tb/lru_replacement_tracker_test.sv
